### rtl/b64c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, codes and character helpers for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    // Input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_START   = 3'd1;
    localparam logic [2:0] ST_END     = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    // Register indexes
    localparam logic REG_ENCODE_MODE = 1'b0;

    // Character codes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    // One queued job: up to four data results, then an optional marker
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      n_data;
        logic            has_tail;
        logic [2:0]      tail_status;
    } t_job;

    // Alphabet character for a 6-bit value
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = CH_UPPER_A + w;
        end else if (v < 6'd52) begin
            c = CH_LOWER_A + (w - 8'd26);
        end else if (v < 6'd62) begin
            c = CH_DIGIT_0 + (w - 8'd52);
        end else if (v == 6'd62) begin
            c = CH_PLUS;
        end else begin
            c = CH_SLASH;
        end
        return c;
    endfunction

    // Symbol value: bit 6 set means not in the alphabet
    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'h40;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = c - CH_UPPER_A;
            r = {1'b0, d[5:0]};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = c - CH_LOWER_A + 8'd26;
            r = {1'b0, d[5:0]};
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d = c - CH_DIGIT_0 + 8'd52;
            r = {1'b0, d[5:0]};
        end else if (c == CH_PLUS) begin
            r = 7'd62;
        end else if (c == CH_SLASH) begin
            r = 7'd63;
        end
        return r;
    endfunction

    // Encode n (1..3) bytes into four characters, padded with '='
    function automatic t_job enc_group(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [1:0] n);
        t_job       j;
        logic [7:0] x1;
        logic [7:0] x2;
        x1 = (n > 2'd1) ? b1 : 8'd0;
        x2 = (n > 2'd2) ? b2 : 8'd0;
        j.data[0]     = enc_char(x1[7:2] & 6'h00 | b0[7:2]);
        j.data[1]     = enc_char({b0[1:0], x1[7:4]});
        j.data[2]     = (n > 2'd1) ? enc_char({x1[3:0], x2[7:6]}) : CH_PAD;
        j.data[3]     = (n > 2'd2) ? enc_char(x2[5:0]) : CH_PAD;
        j.n_data      = 3'd4;
        j.has_tail    = 1'b0;
        j.tail_status = ST_DATA;
        return j;
    endfunction

    // Decode four characters into one to three bytes, or flag an invalid symbol
    function automatic t_job dec_group(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3);
        t_job       j;
        logic       pad2;
        logic       pad3;
        logic [2:0] nsym;
        logic [6:0] s0;
        logic [6:0] s1;
        logic [6:0] s2;
        logic [6:0] s3;
        logic [5:0] v2;
        logic [5:0] v3;
        logic       bad;
        pad2 = (c2 == CH_PAD);
        pad3 = (c3 == CH_PAD);
        nsym = pad3 ? (pad2 ? 3'd2 : 3'd3) : 3'd4;
        s0 = sym_value(c0);
        s1 = sym_value(c1);
        s2 = sym_value(c2);
        s3 = sym_value(c3);
        bad = (pad2 && !pad3) || s0[6] || s1[6]
            || (nsym > 3'd2 && s2[6]) || (nsym > 3'd3 && s3[6]);
        v2 = (nsym > 3'd2) ? s2[5:0] : 6'd0;
        v3 = (nsym > 3'd3) ? s3[5:0] : 6'd0;
        j.data[0] = {s0[5:0], s1[5:4]};
        j.data[1] = {s1[3:0], v2[5:2]};
        j.data[2] = {v2[1:0], v3};
        j.data[3] = 8'd0;
        if (bad) begin
            j.n_data      = 3'd0;
            j.has_tail    = 1'b1;
            j.tail_status = ST_INVALID;
        end else begin
            j.n_data      = nsym - 3'd1;
            j.has_tail    = 1'b0;
            j.tail_status = ST_DATA;
        end
        return j;
    endfunction

endpackage

### rtl/b64c_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input transactions, gathers groups and turns each start, end and
// completed group into a job for the output side.
// ----------------------------------------------------------------------------
module b64c_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [1:0]      i_action,
    input  logic [7:0]      i_data_in,
    input  logic            i_cfg_wr,
    input  logic            i_cfg_mode,
    output logic            o_encode_mode,
    output logic            o_job_valid,
    output b64c_pkg::t_job  o_job
);

    logic            r_encode_mode;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic [7:0]      r_buf [3];
    b64c_pkg::t_job  w_job;
    logic            w_push;
    logic            w_store;

    // Classify the accepted item
    always_comb begin
        n_count = r_count;
        w_push  = 1'b0;
        w_store = 1'b0;
        w_job   = '0;
        if (i_accept) begin
            case (i_action)
                b64c_pkg::ACT_START: begin
                    n_count           = 2'd0;
                    w_push            = 1'b1;
                    w_job.has_tail    = 1'b1;
                    w_job.tail_status = b64c_pkg::ST_START;
                end
                b64c_pkg::ACT_DATA: begin
                    if (r_encode_mode && r_count == 2'd2) begin
                        n_count = 2'd0;
                        w_push  = 1'b1;
                        w_job   = b64c_pkg::enc_group(r_buf[0], r_buf[1], i_data_in, 2'd3);
                    end else if (!r_encode_mode && r_count == 2'd3) begin
                        n_count = 2'd0;
                        w_push  = 1'b1;
                        w_job   = b64c_pkg::dec_group(r_buf[0], r_buf[1], r_buf[2],
                                                      i_data_in);
                    end else begin
                        n_count = r_count + 2'd1;
                        w_store = 1'b1;
                    end
                end
                b64c_pkg::ACT_END: begin
                    n_count = 2'd0;
                    w_push  = 1'b1;
                    if (r_encode_mode) begin
                        if (r_count != 2'd0) begin
                            w_job = b64c_pkg::enc_group(r_buf[0], r_buf[1], 8'd0, r_count);
                        end
                        w_job.has_tail    = 1'b1;
                        w_job.tail_status = b64c_pkg::ST_END;
                    end else begin
                        w_job.has_tail    = 1'b1;
                        w_job.tail_status = (r_count != 2'd0) ? b64c_pkg::ST_TRUNC
                                                              : b64c_pkg::ST_END;
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // Mode and group count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encode_mode <= 1'b1;
            r_count       <= 2'd0;
        end else if (i_cfg_wr) begin
            r_encode_mode <= i_cfg_mode;
            r_count       <= 2'd0;
        end else begin
            r_count       <= n_count;
        end
    end

    // Group buffer, no reset
    always_ff @(posedge i_clk) begin
        if (w_store && r_count != 2'd3) begin
            r_buf[r_count] <= i_data_in;
        end
    end

    assign o_encode_mode = r_encode_mode;
    assign o_job_valid   = w_push;
    assign o_job         = w_job;

endmodule

### rtl/b64c_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_queue
// Small job queue between the front and the output side.
// ----------------------------------------------------------------------------
module b64c_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64c_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output b64c_pkg::t_job  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64c_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### rtl/b64c_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_back
// Expands the job at the queue head into results, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64c_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  b64c_pkg::t_job  i_head,
    output logic            o_pop,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_data_out,
    output logic [2:0]      o_status,
    output logic            o_last
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [2:0] r_status;
    logic       r_last;
    logic [2:0] r_idx;
    logic [2:0] w_total;
    logic       w_load;
    logic       w_is_last;
    logic [7:0] w_data;
    logic [2:0] w_status;

    assign w_total   = i_head.n_data + {2'b00, i_head.has_tail};
    assign w_load    = !i_empty && (!r_valid || i_out_ready);
    assign w_is_last = (r_idx == w_total - 3'd1);
    assign o_pop     = w_load && w_is_last;

    // Select the result at the current index
    always_comb begin
        if (r_idx < i_head.n_data) begin
            w_data   = i_head.data[r_idx[1:0]];
            w_status = b64c_pkg::ST_DATA;
        end else begin
            w_data   = 8'd0;
            w_status = i_head.tail_status;
        end
    end

    // Index within the head job and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_is_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data   <= w_data;
            r_status <= w_status;
            r_last   <= w_is_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_data_out  = r_data;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

### rtl/base64_stream_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// The codec takes one input transaction per cycle while its job queue
// (QUEUE_DEPTH entries) has room, and delivers one result per cycle while
// i_out_ready is high; the output stage sets the sustained rate. Encoding
// gives four characters per three bytes; decoding gives at most three bytes
// per four characters, so it keeps up at one character per cycle. Start, end
// and error items each give one result, and an end with a partial encode group
// gives five. The first result of an item passes the job queue and then the
// output register. encode_mode sits at byte address 0 (aliased at 1 to 3) and
// is to be written only while idle; the block itself does not enforce this. A
// write also empties the current group. The group buffer has no reset.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_out,
    output logic [2:0]  o_status,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            w_accept;
    logic            w_cfg_wr;
    logic            w_mode;
    logic            w_job_valid;
    b64c_pkg::t_job  w_job;
    b64c_pkg::t_job  w_head;
    logic            w_full;
    logic            w_empty;
    logic            w_pop;

    // Register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == b64c_pkg::REG_ENCODE_MODE);
    assign prdata   = (paddr[2] == b64c_pkg::REG_ENCODE_MODE) ? {31'd0, w_mode} : 32'd0;

    // Input handshake
    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && !w_full;

    b64c_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_action      (i_action),
        .i_data_in     (i_data_in),
        .i_cfg_wr      (w_cfg_wr),
        .i_cfg_mode    (pwdata[0]),
        .o_encode_mode (w_mode),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    b64c_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
